// ===== rtl/core/wsd_pkg.sv =====
// Shared types and codes for the WebSocket frame deframer.
package wsd_pkg;

   localparam int LENGTH_WIDTH_DEF = 16;
   localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd8176;

   localparam int TDATA_WIDTH = 16;
   localparam int TUSER_WIDTH = 2;

   // Parser phases
   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_DISCARD = 3'd5;

   // Result status codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FIN      = 3'd1;
   localparam logic [2:0] ST_BIG      = 3'd2;
   localparam logic [2:0] ST_UNMASKED = 3'd3;
   localparam logic [2:0] ST_OPCODE   = 3'd4;
   localparam logic [2:0] ST_TRUNC    = 3'd5;

   // Opcodes and header encodings
   localparam logic [3:0] OP_BINARY  = 4'h2;
   localparam logic [3:0] OP_PING    = 4'h9;
   localparam logic [6:0] LEN_EXT16  = 7'd126;
   localparam logic [6:0] LEN_EXT64  = 7'd127;
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       read_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_data;
      logic       frame_kind;
      logic       frame_last;
      logic [2:0] status;
   } rsp_item_type;

endpackage

// ===== rtl/core/wsd_in_stage.sv =====
// Input register stage of the deframer.
module wsd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  wsd_pkg::req_item_type req_item,
   input  logic                 advance,
   output logic                 item_valid,
   output wsd_pkg::req_item_type item
);
   import wsd_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = (req_tvalid && req_tready) ? 1'b1 : (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the item until the parser takes it
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/wsd_parser.sv =====
// Frame header parser, key capture and payload unmasking.
module wsd_parser #(
   parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [15:0]           csr_data,
   input  logic                  advance,
   input  wsd_pkg::req_item_type item,
   output logic                  emit,
   output wsd_pkg::rsp_item_type result
);
   import wsd_pkg::*;

   localparam logic [15:0] LimitCap = (LENGTH_WIDTH >= 16) ? 16'hFFFF :
                                      16'((32'd1 << LENGTH_WIDTH) - 32'd1);

   logic [15:0]             max_len_ff;
   logic [2:0]              phase_ff, phase_in;
   logic [3:0]              opcode_ff, opcode_in;
   logic                    mask_ff, mask_in;
   logic [15:0]             acc_ff, acc_in;
   logic                    ovf_ff, ovf_in;
   logic [3:0]              lbl_ff, lbl_in;
   logic [31:0]             key_ff, key_in;
   logic [2:0]              kbl_ff, kbl_in;
   logic [LENGTH_WIDTH-1:0] rem_ff, rem_in;
   logic [1:0]              kidx_ff, kidx_in;

   logic [15:0]  limit;
   logic [2:0]   err;
   logic [2:0]   chk;
   logic         do_check;
   logic [7:0]   key_byte;
   logic [7:0]   b;
   rsp_item_type res;

   assign b     = item.rx_byte;
   assign limit = (max_len_ff < LimitCap) ? max_len_ff : LimitCap;

   always_comb begin
      case (kidx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      lbl_in    = lbl_ff;
      key_in    = key_ff;
      kbl_in    = kbl_ff;
      rem_in    = rem_ff;
      kidx_in   = kidx_ff;
      emit      = 1'b0;
      res       = '0;
      err       = ST_OK;
      do_check  = 1'b0;

      case (phase_ff)
         PH_HDR0: begin
            opcode_in = b[3:0];
            if (!b[7]) begin
               err = ST_FIN;
            end else begin
               phase_in = PH_HDR1;
            end
         end
         PH_HDR1: begin
            mask_in = b[7];
            ovf_in  = 1'b0;
            if (b[6:0] == LEN_EXT16) begin
               acc_in   = '0;
               lbl_in   = EXT16_BYTES;
               phase_in = PH_EXTLEN;
            end else if (b[6:0] == LEN_EXT64) begin
               acc_in   = '0;
               lbl_in   = EXT64_BYTES;
               phase_in = PH_EXTLEN;
            end else begin
               acc_in   = {9'd0, b[6:0]};
               do_check = 1'b1;
            end
         end
         PH_EXTLEN: begin
            // keep the low 16 bits, fold anything shifted out into a sticky flag
            acc_in   = {acc_ff[7:0], b};
            ovf_in   = ovf_ff || (acc_ff[15:8] != 8'd0);
            lbl_in   = lbl_ff - 4'd1;
            do_check = (lbl_in == 4'd0);
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], b};
            kbl_in = kbl_ff - 3'd1;
            if (kbl_in == 3'd0) begin
               if (rem_ff == '0) begin
                  emit           = 1'b1;
                  res.frame_kind = (opcode_ff == OP_PING);
                  res.frame_last = 1'b1;
                  phase_in       = PH_DISCARD;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            emit             = 1'b1;
            res.payload_byte = b ^ key_byte;
            res.has_data     = 1'b1;
            res.frame_kind   = (opcode_ff == OP_PING);
            kidx_in          = kidx_ff + 2'd1;
            rem_in           = rem_ff - LENGTH_WIDTH'(1);
            if (rem_in == '0) begin
               res.frame_last = 1'b1;
               phase_in       = PH_DISCARD;
            end
         end
         default: begin
            phase_in = PH_DISCARD;
         end
      endcase

      // header checks in priority order: size, mask, opcode
      if (ovf_in || (acc_in > limit)) begin
         chk = ST_BIG;
      end else if (!mask_in) begin
         chk = ST_UNMASKED;
      end else if ((opcode_ff != OP_PING) && (opcode_ff != OP_BINARY)) begin
         chk = ST_OPCODE;
      end else begin
         chk = ST_OK;
      end

      if (do_check) begin
         if (chk != ST_OK) begin
            err = chk;
         end else begin
            rem_in   = LENGTH_WIDTH'(acc_in);
            kbl_in   = KEY_BYTES;
            key_in   = '0;
            kidx_in  = '0;
            phase_in = PH_KEY;
         end
      end

      if (err != ST_OK) begin
         emit           = 1'b1;
         res            = '0;
         res.frame_last = 1'b1;
         res.status     = err;
         phase_in       = PH_DISCARD;
      end

      if (item.read_end) begin
         if (phase_in != PH_DISCARD) begin
            emit           = 1'b1;
            res.status     = ST_TRUNC;
            res.frame_last = 1'b1;
            if (!res.has_data) begin
               res.frame_kind = (phase_in == PH_KEY) && (opcode_in == OP_PING);
            end
         end
         phase_in = PH_HDR0;
      end
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_PAYLOAD_RESET;
      end else if (csr_write) begin
         max_len_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= '0;
         mask_ff   <= 1'b0;
         acc_ff    <= '0;
         ovf_ff    <= 1'b0;
         lbl_ff    <= '0;
         key_ff    <= '0;
         kbl_ff    <= '0;
         rem_ff    <= '0;
         kidx_ff   <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         acc_ff    <= acc_in;
         ovf_ff    <= ovf_in;
         lbl_ff    <= lbl_in;
         key_ff    <= key_in;
         kbl_ff    <= kbl_in;
         rem_ff    <= rem_in;
         kidx_ff   <= kidx_in;
      end
   end

endmodule

// ===== rtl/core/wsd_out_stage.sv =====
// Result register stage of the deframer.
module wsd_out_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  emit,
   input  wsd_pkg::rsp_item_type result,
   output logic                  can_take,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output wsd_pkg::rsp_item_type rsp_item
);
   import wsd_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign can_take = !valid_ff || rsp_tready;
   assign valid_in = load ? emit : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && emit) begin
         item_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

// ===== rtl/core/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer.
//
// Takes one received byte per cycle unless rsp_tready stalls it, and parses one
// RFC 6455 frame per socket read (req_tlast marks the read's last byte): header,
// 16- or 64-bit extended length, 4-byte masking key, then unmasked payload bytes
// tagged binary or ping, with rsp_tlast on the last byte of the frame. An empty
// payload gives one result without data. Header errors (FIN clear, too long,
// unmasked, bad opcode) give one result with rsp_tlast and the error status,
// after which bytes are dropped until the end of the read; a read that stops
// mid-frame gives status truncated. Throughput is one byte per cycle with the
// same condition; each byte passes an input register, the parse and unmask
// logic and a result register, which offers the result on rsp_tvalid; a stall
// on rsp_tready holds the byte in the input register. Header bytes that give
// no result still pass through the parser. Write max_payload_len on
// the csr channel only while the block is idle; it resets to 8176.
module websocket_frame_deframer #(
   parameter int LENGTH_WIDTH = wsd_pkg::LENGTH_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: rx_byte [7:0]; req_tlast: read_end
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   input  logic                            req_tlast,
   // rsp_tdata: payload_byte [7:0], status [10:8], zero [15:11]
   // rsp_tuser: has_data [0], frame_kind [1]; rsp_tlast: frame_last
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [wsd_pkg::TDATA_WIDTH-1:0] rsp_tdata,
   output logic [wsd_pkg::TUSER_WIDTH-1:0] rsp_tuser,
   output logic                            rsp_tlast,
   // csr_data: max_payload_len
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [15:0]                     csr_data
);
   import wsd_pkg::*;

   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_item;
   logic         item_valid;
   logic         can_take;
   logic         advance;
   logic         emit;

   assign req_item.rx_byte  = req_tdata;
   assign req_item.read_end = req_tlast;

   // the register is always writable
   assign csr_ready = 1'b1;

   // advance the held byte whenever the result register is free or draining
   assign advance = item_valid && can_take;

   wsd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   wsd_parser #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .advance   (advance),
      .item      (item),
      .emit      (emit),
      .result    (result)
   );

   wsd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .emit       (emit),
      .result     (result),
      .can_take   (can_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {5'd0, rsp_item.status, rsp_item.payload_byte};
   assign rsp_tuser = {rsp_item.frame_kind, rsp_item.has_data};
   assign rsp_tlast = rsp_item.frame_last;

   // payload bytes only travel with ok or truncated status
   a_data_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         (rsp_tdata[10:8] == ST_OK) || (rsp_tdata[10:8] == ST_TRUNC))
      else $error("payload byte carried with an error status");

   // every error or truncation closes the frame
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[10:8] != ST_OK) |-> rsp_tlast)
      else $error("error result without frame end");

   // no data means a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[7:0] == 8'd0))
      else $error("non-zero byte on a result without data");

   // the input side never stalls while the result side is empty
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty result register");

endmodule

// ===== tb/wsd_checker.sv =====
// Scoreboard for the WebSocket frame deframer: predicts every result and checks it.
module wsd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   input  logic                            req_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [wsd_pkg::TDATA_WIDTH-1:0] rsp_tdata,
   input  logic [wsd_pkg::TUSER_WIDTH-1:0] rsp_tuser,
   input  logic                            rsp_tlast,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [15:0]                     csr_data,
   output int                              pending,
   output int                              fail_count,
   output int                              checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import wsd_pkg::*;

   localparam int LEN_W = LENGTH_WIDTH_DEF;

   // parser state of the prediction
   logic [2:0]       parse_phase;
   logic [3:0]       opcode_q;
   logic             masked_q;
   logic [63:0]      length_acc;
   logic [3:0]       length_left;
   logic [31:0]      key_word;
   logic [2:0]       key_left;
   logic [LEN_W-1:0] payload_left;
   logic [1:0]       key_pos;
   logic [15:0]      limit_reg;

   rsp_item_type     expected_q[$];
   int               fails = 0;
   int               checked = 0;

   task automatic report_mismatch(input string what, input int expv, input int gotv);
      if (fails < 50)
         $display("%0t ns deframer result %0d: %s expected %0d, got %0d",
                  $time, checked, what, expv, gotv);
      fails++;
   endtask

   // Header checks once the length is complete; on success arm the key phase.
   function automatic logic [2:0] header_verdict();
      logic [63:0] ceiling;
      ceiling = (64'd1 << LEN_W) - 64'd1;
      if ({48'd0, limit_reg} < ceiling) ceiling = {48'd0, limit_reg};
      if (length_acc > ceiling) return ST_BIG;
      if (!masked_q) return ST_UNMASKED;
      if (opcode_q != OP_PING && opcode_q != OP_BINARY) return ST_OPCODE;
      payload_left = length_acc[LEN_W-1:0];
      key_left     = KEY_BYTES;
      key_word     = '0;
      key_pos      = '0;
      parse_phase  = PH_KEY;
      return ST_OK;
   endfunction

   // Advance the parser by one byte; returns 1 when the byte causes a result.
   function automatic bit deframe_byte(input logic [7:0] b, input logic rend,
                                       output rsp_item_type r);
      logic [2:0] fault;
      bit         emit;
      fault = ST_OK;
      emit  = 1'b0;
      r     = '0;
      case (parse_phase)
         PH_HDR0: begin
            opcode_q = b[3:0];
            if (!b[7]) fault = ST_FIN;
            else parse_phase = PH_HDR1;
         end
         PH_HDR1: begin
            masked_q   = b[7];
            length_acc = {57'd0, b[6:0]};
            if (b[6:0] == LEN_EXT16) begin
               length_acc  = '0;
               length_left = EXT16_BYTES;
               parse_phase = PH_EXTLEN;
            end else if (b[6:0] == LEN_EXT64) begin
               length_acc  = '0;
               length_left = EXT64_BYTES;
               parse_phase = PH_EXTLEN;
            end else begin
               fault = header_verdict();
            end
         end
         PH_EXTLEN: begin
            length_acc  = {length_acc[55:0], b};
            length_left = length_left - 4'd1;
            if (length_left == 4'd0) fault = header_verdict();
         end
         PH_KEY: begin
            key_word = {key_word[23:0], b};
            key_left = key_left - 3'd1;
            if (key_left == 3'd0) begin
               if (payload_left == '0) begin
                  // empty payload: one result without data
                  emit         = 1'b1;
                  r.frame_kind = (opcode_q == OP_PING);
                  r.frame_last = 1'b1;
                  parse_phase  = PH_DISCARD;
               end else begin
                  parse_phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            emit           = 1'b1;
            r.payload_byte = b ^ key_word[8 * (3 - int'(key_pos)) +: 8];
            r.has_data     = 1'b1;
            r.frame_kind   = (opcode_q == OP_PING);
            key_pos        = key_pos + 2'd1;
            payload_left   = payload_left - LEN_W'(1);
            if (payload_left == '0) begin
               r.frame_last = 1'b1;
               parse_phase  = PH_DISCARD;
            end
         end
         default: parse_phase = PH_DISCARD;
      endcase

      if (fault != ST_OK) begin
         emit         = 1'b1;
         r            = '0;
         r.frame_last = 1'b1;
         r.status     = fault;
         parse_phase  = PH_DISCARD;
      end

      // end of read: anything unfinished is truncated, then restart at the header
      if (rend) begin
         if (parse_phase != PH_DISCARD) begin
            emit         = 1'b1;
            r.status     = ST_TRUNC;
            r.frame_last = 1'b1;
            if (!r.has_data) r.frame_kind = (parse_phase == PH_KEY && opcode_q == OP_PING);
         end
         parse_phase = PH_HDR0;
      end
      return emit;
   endfunction

   always @(posedge clock) begin
      rsp_item_type outcome;
      rsp_item_type want;
      if (reset) begin
         parse_phase  = PH_HDR0;
         opcode_q     = '0;
         masked_q     = 1'b0;
         length_acc   = '0;
         length_left  = '0;
         key_word     = '0;
         key_left     = '0;
         payload_left = '0;
         key_pos      = '0;
         limit_reg    = MAX_PAYLOAD_RESET;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) limit_reg = csr_data;
         if (req_tvalid && req_tready) begin
            if (deframe_byte(req_tdata, req_tlast, outcome)) expected_q.push_back(outcome);
         end
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (expected_q.size() == 0) begin
               report_mismatch("result with nothing expected, tdata", -1, int'(rsp_tdata));
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata[7:0] != want.payload_byte)
                  report_mismatch("payload_byte", int'(want.payload_byte),
                                  int'(rsp_tdata[7:0]));
               if (rsp_tdata[10:8] != want.status)
                  report_mismatch("status", int'(want.status), int'(rsp_tdata[10:8]));
               if (rsp_tuser[0] != want.has_data)
                  report_mismatch("has_data", int'(want.has_data), int'(rsp_tuser[0]));
               if (rsp_tuser[1] != want.frame_kind)
                  report_mismatch("frame_kind", int'(want.frame_kind), int'(rsp_tuser[1]));
               if (rsp_tlast != want.frame_last)
                  report_mismatch("frame_last", int'(want.frame_last), int'(rsp_tlast));
            end
         end
      end
      pending       <= expected_q.size();
      fail_count    <= fails;
      checked_count <= checked;
   end

endmodule

// ===== tb/tb_websocket_frame_deframer.sv =====
// Testbench top for the WebSocket frame deframer: stimulus, idling and verdict.
module tb_websocket_frame_deframer;
   timeunit 1ns;
   timeprecision 1ps;
   import wsd_pkg::*;

   localparam int PAYLOAD_CAP = 200;   // longest payload actually sent in one read

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [TDATA_WIDTH-1:0] rsp_tdata;
   logic [TUSER_WIDTH-1:0] rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [15:0]            csr_data = '0;

   int pending;
   int fail_count;
   int checked_count;

   logic [7:0]  read_buf[$];               // bytes of the socket read being built
   logic [15:0] limit_now = MAX_PAYLOAD_RESET;
   int          src_mode = 1;
   int          sink_mode = 1;
   int          bytes_sent = 0;
   int          reads_sent = 0;
   int          settings_used = 0;

   always #1 clock = ~clock;

   websocket_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   wsd_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .pending       (pending),
      .fail_count    (fail_count),
      .checked_count (checked_count)
   );

   // Cycles to wait before an item: none, occasional gaps, or a random gap, possibly none, before every item.
   function automatic int idle_draw(input int mode);
      case (mode)
         0:       return 0;
         1:       return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
         default: return $urandom_range(0, 13);
      endcase
   endfunction

   // Build one frame into read_buf: header, length in the chosen form
   // (0 short, 1 16-bit, 2 64-bit), masking key and payload.
   task automatic build_frame(input logic fin, input logic [3:0] op, input logic masked,
                              input logic [63:0] len, input int form);
      int n;
      read_buf.delete();
      read_buf.push_back({fin, 3'($urandom_range(0, 7)), op});
      case (form)
         0: read_buf.push_back({masked, len[6:0]});
         1: begin
            read_buf.push_back({masked, LEN_EXT16});
            read_buf.push_back(len[15:8]);
            read_buf.push_back(len[7:0]);
         end
         default: begin
            read_buf.push_back({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--) read_buf.push_back(len[8 * i +: 8]);
         end
      endcase
      repeat (4) read_buf.push_back(8'($urandom));
      // an oversized frame is rejected in the header, so follow it with a little junk only
      if (len > {48'd0, limit_now}) n = $urandom_range(0, 3);
      else n = (len > 64'(PAYLOAD_CAP)) ? PAYLOAD_CAP : int'(len);
      repeat (n) read_buf.push_back(8'($urandom));
   endtask

   // Keep only the first n bytes, so the read ends inside the frame.
   task automatic cut_read(input int n);
      while (read_buf.size() > n) void'(read_buf.pop_back());
   endtask

   // Send read_buf as one socket read, read_end on its last byte.
   // Valid stays high after each item unless a gap follows.
   task automatic send_read();
      int gap;
      foreach (read_buf[i]) begin
         gap = idle_draw(src_mode);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= read_buf[i];
         req_tlast  <= (i == read_buf.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         bytes_sent++;
      end
      reads_sent++;
   endtask

   // Hold the source until every expected result has been taken.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Write max_payload_len with the block idle.
   task automatic set_limit(input logic [15:0] value);
      drain_results();
      // header bytes still in flight give no result: let them clear
      repeat (6) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      limit_now = value;
      settings_used++;
   endtask

   // One random socket read: mostly well-formed frames, the rest broken or noise.
   task automatic random_read();
      int          pick;
      int          r;
      int          form;
      logic [63:0] len;
      logic [3:0]  op;
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, 19);
      if (r < 11)      len = $urandom_range(0, 16);
      else if (r < 16) len = $urandom_range(17, 128);
      else if (r < 18) len = $urandom_range(129, 300);
      else if (r < 19) len = {48'd0, limit_now} + 64'($urandom_range(0, 1));
      else             len = $urandom_range(0, 65535);
      if (len < 64'd126)        form = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      else if (len < 64'd65536) form = $urandom_range(1, 2);
      else                      form = 2;
      op = $urandom_range(0, 1) ? OP_PING : OP_BINARY;

      if (pick < 70) begin
         build_frame(1'b1, op, 1'b1, len, form);
         // trailing bytes after a finished frame are dropped up to the read end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) read_buf.push_back(8'($urandom));
      end else if (pick < 76) begin
         build_frame(1'b0, 4'($urandom), 1'($urandom), len, form);
      end else if (pick < 82) begin
         build_frame(1'b1, op, 1'b0, len, form);
      end else if (pick < 88) begin
         do op = 4'($urandom); while (op == OP_BINARY || op == OP_PING);
         build_frame(1'b1, op, 1'b1, len, form);
      end else if (pick < 95) begin
         build_frame(1'b1, op, 1'b1, len, form);
         cut_read($urandom_range(1, read_buf.size() - 1));
      end else if (pick < 98) begin
         // any 64-bit length, usually far too big
         build_frame(1'b1, op, 1'b1, {$urandom, $urandom}, 2);
      end else begin
         read_buf.delete();
         repeat ($urandom_range(1, 8)) read_buf.push_back(8'($urandom));
      end
      send_read();
   endtask

   // Result side: draw a stall before every result, per the current sink mode.
   initial begin
      int stall;
      forever begin
         stall = idle_draw(sink_mode);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      logic [15:0] value;
      int          phase_start;
      bit          held;
      held = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed reads under the reset limit.
      // empty binary frame, then a ping with trailing junk dropped
      build_frame(1'b1, OP_BINARY, 1'b1, 64'd0, 0);
      send_read();
      build_frame(1'b1, OP_PING, 1'b1, 64'd3, 0);
      read_buf.push_back(8'hFF);
      read_buf.push_back(8'h00);
      send_read();
      // 16-bit and 64-bit extended lengths
      build_frame(1'b1, OP_BINARY, 1'b1, 64'd2, 1);
      send_read();
      build_frame(1'b1, OP_PING, 1'b1, 64'd1, 2);
      send_read();
      // FIN clear on a one-byte read, unmasked frame, unsupported opcode
      build_frame(1'b0, OP_BINARY, 1'b1, 64'd0, 0);
      cut_read(1);
      send_read();
      build_frame(1'b1, OP_BINARY, 1'b0, 64'd4, 0);
      send_read();
      build_frame(1'b1, 4'h1, 1'b1, 64'd0, 0);
      send_read();
      // too big: 64-bit length with its top bit set, then one over the limit
      build_frame(1'b1, OP_BINARY, 1'b1, 64'h8000_0000_0000_0001, 2);
      send_read();
      build_frame(1'b1, OP_PING, 1'b1, {48'd0, limit_now} + 64'd1, 1);
      send_read();
      // truncated reads: in the header, the extended length, the key of a ping,
      // right after the key, and inside the payload
      build_frame(1'b1, OP_BINARY, 1'b1, 64'd5, 0);
      cut_read(1);
      send_read();
      build_frame(1'b1, OP_BINARY, 1'b1, 64'd5, 1);
      cut_read(3);
      send_read();
      build_frame(1'b1, OP_PING, 1'b1, 64'd5, 0);
      cut_read(4);
      send_read();
      build_frame(1'b1, OP_PING, 1'b1, 64'd5, 0);
      cut_read(6);
      send_read();
      build_frame(1'b1, OP_PING, 1'b1, 64'd5, 0);
      cut_read(8);
      send_read();
      // all-ones and all-zero bytes
      read_buf = {8'hFF, 8'hFF, 8'hFF};
      send_read();
      read_buf = {8'h00, 8'h00};
      send_read();

      // Random reads over several limits, extremes first.
      for (int p = 0; p < 7; p++) begin
         case (p)
            0:       value = 16'd0;
            1:       value = 16'hFFFF;
            2:       value = 16'd1;
            3:       value = 16'($urandom_range(2, 40));
            4:       value = 16'($urandom_range(41, 700));
            5:       value = 16'($urandom);
            default: value = MAX_PAYLOAD_RESET;
         endcase
         set_limit(value);
         src_mode  = p % 3;
         sink_mode = $urandom_range(0, 2);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < 290) begin
            random_read();
            // once, mid-phase: hold the source until the block has drained
            if (p == 3 && !held && bytes_sent - phase_start > 140) begin
               drain_results();
               held = 1'b1;
            end
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      $display("Covered %0d reads (%0d bytes) under %0d written payload limits,",
               reads_sent, bytes_sent, settings_used);
      $display("with %0d results compared field by field.", checked_count);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
